// File: rtl/pipt_pkg.sv
// Shared types and constants for the point-in-polygon test block.
`default_nettype none

package pipt_pkg;

    // Widths of the input fields and of the derived arithmetic.
    localparam int COORD_W = 16;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    // Item kinds.
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_TEST  = 1'b1;

    // One stored polygon vertex.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_vertex;

    // Tag that travels with a vertex read out of the table.
    typedef struct packed {
        logic vld;
        logic first;
    } t_rd_ctrl;

    // Status of the edge pipeline toward the sequencer.
    typedef struct packed {
        logic busy;
        logic flip_vld;
        logic flip;
    } t_edge_stat;

endpackage

`default_nettype wire

// File: rtl/pipt_ifs.sv
// Handshake channel interfaces for items, results and the vertex count register.
`default_nettype none

interface pipt_item_if
    import pipt_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic                      kind;
    logic [INDEX_W-1:0]        vertex_index;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;

    modport source (output valid, kind, vertex_index, coord_x, coord_y, input ready);
    modport sink   (input valid, kind, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pipt_res_if;
    logic valid;
    logic ready;
    logic inside_res;

    modport source (output valid, inside_res, input ready);
    modport sink   (input valid, inside_res, output ready);
endinterface

interface pipt_cfg_if
    import pipt_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] vertex_count;

    modport source (output valid, vertex_count, input ready);
    modport sink   (input valid, vertex_count, output ready);
endinterface

`default_nettype wire

// File: rtl/point_in_polygon_test_core.sv
// Top level of the point-in-polygon test block: sequencer, table and edge pipeline.
//
// Channels: i_item takes requests, o_res gives results, i_cfg sets the vertex count.
// A write request (kind 0) stores one vertex in the table in the cycle it is taken
// and gives no result; writes to a slot at or above MAX_VERTICES are dropped.
// A test request (kind 1) walks every edge of the first vertex_count vertices
// (saturated at MAX_VERTICES) and gives one inside flag by the even-odd rule.
// For n vertices in use, the table's single read port delivers one vertex a cycle,
// n + 1 reads in all, and the edge pipeline registers the differences, then the
// products, and then compares them. With a count of zero the flag is 0.
// Requests are taken only while the sequencer is idle, so a new test is not taken
// until the result of the last one is in the output register.
// The result sits in an output register, so the next request is taken while an
// earlier result waits; a finished test holds in its last state while the
// receiver stalls and the output register is still full.
// Reset clears the sequencer, the count register and the output valid; the
// vertex table is not cleared and every slot in use must be written first.
`default_nettype none

module point_in_polygon_test_core
    import pipt_pkg::*;
#(
    parameter int MAX_VERTICES = 16
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    pipt_item_if.sink i_item,
    pipt_cfg_if.sink  i_cfg,
    pipt_res_if.source o_res
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_WALK  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [COUNT_W-1:0]        r_vcount;
    logic [CW-1:0]             r_n;
    logic [CW-1:0]             n_n;
    logic [CW-1:0]             r_rd_cnt;
    logic [CW-1:0]             rd_addr_full;
    logic signed [COORD_W-1:0] r_tx;
    logic signed [COORD_W-1:0] r_ty;
    logic                      r_inside;
    logic                      r_out_vld;
    logic                      r_out_bit;
    t_rd_ctrl                  r_rd_ctrl;
    t_edge_stat                edge_stat;
    t_vertex                   rd_data;
    t_vertex                   wr_data;
    logic                      item_acc;
    logic                      wr_en;
    logic                      rd_en;
    logic                      out_load;

    // Configuration register; writes must only come while idle, which the block itself does not enforce.
    assign i_cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcount <= '0;
        end else if (i_cfg.valid) begin
            r_vcount <= i_cfg.vertex_count;
        end
    end

    // Count in use, saturated at the table depth.
    assign n_n = (32'(r_vcount) > MAX_VERTICES) ? CW'(MAX_VERTICES) : CW'(r_vcount);

    assign i_item.ready = (r_state == ST_IDLE);
    assign item_acc     = i_item.valid && i_item.ready;

    // Table write for a vertex request inside the table.
    assign wr_en        = item_acc && (i_item.kind == KIND_WRITE)
                          && (32'(i_item.vertex_index) < MAX_VERTICES);
    assign wr_data.x    = i_item.coord_x;
    assign wr_data.y    = i_item.coord_y;

    // Read order: the last vertex first, then the vertices from the first on.
    assign rd_en        = (r_state == ST_WALK);
    assign rd_addr_full = (r_rd_cnt == '0) ? (r_n - CW'(1)) : (r_rd_cnt - CW'(1));

    pipt_vtx_mem #(
        .DEPTH (MAX_VERTICES),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (AW'(i_item.vertex_index)),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr_full[AW-1:0]),
        .o_rdata (rd_data)
    );

    pipt_edge_unit u_edge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (r_rd_ctrl),
        .i_vtx   (rd_data),
        .i_tx    (r_tx),
        .i_ty    (r_ty),
        .o_stat  (edge_stat)
    );

    // Result register loads when the test is done and the slot is free.
    assign out_load = (r_state == ST_DONE) && (!r_out_vld || o_res.ready);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (item_acc && (i_item.kind == KIND_TEST)) begin
                    n_state = (n_n == '0) ? ST_DONE : ST_WALK;
                end
            end
            ST_WALK: begin
                if (r_rd_cnt == r_n) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!r_rd_ctrl.vld && !edge_stat.busy) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Sequencer and control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rd_ctrl <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_rd_ctrl.vld   <= rd_en;
            r_rd_ctrl.first <= rd_en && (r_rd_cnt == '0);
            if (out_load) begin
                r_out_vld <= 1'b1;
            end else if (o_res.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Test point, walk counter and running flag.
    always_ff @(posedge i_clk) begin
        if (item_acc && (i_item.kind == KIND_TEST)) begin
            r_tx     <= i_item.coord_x;
            r_ty     <= i_item.coord_y;
            r_n      <= n_n;
            r_rd_cnt <= '0;
            r_inside <= 1'b0;
        end else begin
            if (rd_en) begin
                r_rd_cnt <= r_rd_cnt + CW'(1);
            end
            if (edge_stat.flip_vld && edge_stat.flip) begin
                r_inside <= !r_inside;
            end
        end
        if (out_load) begin
            r_out_bit <= r_inside;
        end
    end

    assign o_res.valid      = r_out_vld;
    assign o_res.inside_res = r_out_bit;

endmodule

`default_nettype wire

// File: rtl/pipt_vtx_mem.sv
// Vertex table: one write port and one read port with registered read data.
`default_nettype none

module pipt_vtx_mem
    import pipt_pkg::*;
#(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  wire logic    i_clk,
    input  wire logic    i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire t_vertex i_wdata,
    input  wire logic    i_re,
    input  wire logic [AW-1:0] i_raddr,
    output t_vertex      o_rdata
);

    t_vertex r_mem [DEPTH];
    t_vertex r_rdata;

    // Synchronous write.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Synchronous read into a data register.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/pipt_edge_unit.sv
// Edge pipeline: differences, cross products, then the crossing compare.
`default_nettype none

module pipt_edge_unit
    import pipt_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_rd_ctrl i_ctrl,
    input  wire t_vertex  i_vtx,
    input  wire logic signed [COORD_W-1:0] i_tx,
    input  wire logic signed [COORD_W-1:0] i_ty,
    output t_edge_stat    o_stat
);

    // Previous vertex of the walk (the edge's far end).
    t_vertex r_prev;

    // First stage: differences and straddle.
    logic                     r_s1_vld;
    logic                     r_s1_strad;
    logic signed [DIFF_W-1:0] r_d;
    logic signed [DIFF_W-1:0] r_a;
    logic signed [DIFF_W-1:0] r_b;
    logic signed [DIFF_W-1:0] r_c;

    // Second stage: cross products.
    logic                     r_s2_vld;
    logic                     r_s2_strad;
    logic                     r_s2_dpos;
    logic signed [PROD_W-1:0] r_lhs;
    logic signed [PROD_W-1:0] r_rhs;

    logic signed [DIFF_W-1:0] n_d;
    logic signed [DIFF_W-1:0] n_a;
    logic signed [DIFF_W-1:0] n_b;
    logic signed [DIFF_W-1:0] n_c;
    logic                     n_strad;
    logic signed [PROD_W-1:0] n_lhs;
    logic signed [PROD_W-1:0] n_rhs;

    // The current vertex is the edge's near end, the previous one its far end.
    always_comb begin
        n_d = {r_prev.y[COORD_W-1], r_prev.y} - {i_vtx.y[COORD_W-1], i_vtx.y};
        n_a = {i_tx[COORD_W-1], i_tx} - {i_vtx.x[COORD_W-1], i_vtx.x};
        n_b = {r_prev.x[COORD_W-1], r_prev.x} - {i_vtx.x[COORD_W-1], i_vtx.x};
        n_c = {i_ty[COORD_W-1], i_ty} - {i_vtx.y[COORD_W-1], i_vtx.y};
        n_strad = (i_vtx.y > i_ty) != (r_prev.y > i_ty);
    end

    // Products of the registered differences.
    always_comb begin
        n_lhs = r_a * r_d;
        n_rhs = r_b * r_c;
    end

    // Control valids.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_ctrl.vld && !i_ctrl.first;
            r_s2_vld <= r_s1_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.vld) begin
            r_prev <= i_vtx;
        end
        r_s1_strad <= n_strad;
        r_d        <= n_d;
        r_a        <= n_a;
        r_b        <= n_b;
        r_c        <= n_c;
        r_s2_strad <= r_s1_strad;
        r_s2_dpos  <= !r_d[DIFF_W-1];
        r_lhs      <= n_lhs;
        r_rhs      <= n_rhs;
    end

    // The point lies left of the crossing; a straddling edge has a nonzero height.
    always_comb begin
        o_stat.busy     = r_s1_vld || r_s2_vld;
        o_stat.flip_vld = r_s2_vld;
        o_stat.flip     = r_s2_strad && (r_s2_dpos ? (r_lhs < r_rhs) : (r_lhs > r_rhs));
    end

endmodule

`default_nettype wire

// File: sim/point_in_polygon_test_core_test.sv
// Self-checking testbench for the point-in-polygon test block with an even-odd prediction.
`timescale 1ns / 100ps

module point_in_polygon_test_core_test
    import pipt_pkg::*;
;

    localparam int MAX_VERTS   = 16;
    localparam int SETTLE_WAIT = 40;    // cycles waited after the last owed result, with margin
    localparam int QUIET_LIMIT = 4000;  // cycles without any handshake before giving up
    localparam int ITEM_TARGET = 450;

    // One request on the item channel.
    typedef struct packed {
        logic                      kind;
        logic [INDEX_W-1:0]        index;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
    } t_polygon_request;

    // Mirror of the vertex table and count, with the inside flags still owed by the block.
    class t_crossing_scoreboard;
        logic signed [COORD_W-1:0] vert_x [MAX_VERTS];
        logic signed [COORD_W-1:0] vert_y [MAX_VERTS];
        bit                        loaded [MAX_VERTS];
        logic [COUNT_W-1:0]        vertex_count;
        bit                        expected_flags [$];
        int                        mismatches;
        int                        tests_seen;
        int                        writes_seen;
        int                        results_seen;
        int                        flags_set;

        function new();
            vertex_count = '0;
            mismatches   = 0;
            tests_seen   = 0;
            writes_seen  = 0;
            results_seen = 0;
            flags_set    = 0;
            foreach (loaded[k]) begin
                loaded[k] = 1'b0;
                vert_x[k] = '0;
                vert_y[k] = '0;
            end
        endfunction

        // Even-odd crossing count over the first vertex_count vertices, exact in 64 bits.
        function bit crossing_parity(logic signed [COORD_W-1:0] px,
                                     logic signed [COORD_W-1:0] py);
            int     n;
            int     j;
            longint xi, yi, xj, yj, tx, ty, d, lhs, rhs;
            bit     parity;
            parity = 1'b0;
            tx = px;
            ty = py;
            n = (vertex_count > MAX_VERTS) ? MAX_VERTS : int'(vertex_count);
            j = n - 1;
            for (int i = 0; i < n; i++) begin
                xi = vert_x[i];
                yi = vert_y[i];
                xj = vert_x[j];
                yj = vert_y[j];
                // Only edges that straddle the test y can be crossed.
                if ((yi > ty) != (yj > ty)) begin
                    d   = yj - yi;
                    lhs = (tx - xi) * d;
                    rhs = (xj - xi) * (ty - yi);
                    if ((d > 0) ? (lhs < rhs) : (lhs > rhs))
                        parity = ~parity;
                end
                j = i;
            end
            return parity;
        endfunction

        // Called for every accepted request.
        function void note_request(t_polygon_request req);
            bit flag;
            if (req.kind == KIND_WRITE) begin
                writes_seen++;
                if (req.index < MAX_VERTS) begin
                    vert_x[req.index] = req.x;
                    vert_y[req.index] = req.y;
                    loaded[req.index] = 1'b1;
                end
            end else begin
                tests_seen++;
                flag = crossing_parity(req.x, req.y);
                flags_set += flag;
                expected_flags.push_back(flag);
            end
        endfunction

        // Called for every accepted result.
        function void check_result(logic flag);
            bit want;
            results_seen++;
            if (expected_flags.size() == 0) begin
                $error("inside_res arrived with no test pending: actual %0b", flag);
                mismatches++;
            end else begin
                want = expected_flags.pop_front();
                if (flag !== want) begin
                    $error("inside_res mismatch: expected %0b, actual %0b", want, flag);
                    mismatches++;
                end
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    pipt_item_if item_ch ();
    pipt_res_if  res_ch ();
    pipt_cfg_if  cfg_ch ();

    point_in_polygon_test_core #(
        .MAX_VERTICES (MAX_VERTS)
    ) uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    t_crossing_scoreboard parity_board;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_ready_cycles;
    int quiet_cycles;
    int items_sent;
    int counts_written;

    // Free-running clock.
    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Known values on every input from time zero.
    initial begin
        parity_board         = new();
        i_rst_n              = 1'b0;
        item_ch.valid        = 1'b0;
        item_ch.kind         = KIND_WRITE;
        item_ch.vertex_index = '0;
        item_ch.coord_x      = '0;
        item_ch.coord_y      = '0;
        cfg_ch.valid         = 1'b0;
        cfg_ch.vertex_count  = '0;
        res_ch.ready         = 1'b0;
        send_idle_pct        = 0;
        recv_stall_pct       = 0;
        hold_ready_cycles    = 0;
        quiet_cycles         = 0;
        items_sent           = 0;
        counts_written       = 0;
    end

    // Result receiver: a long hold when asked, otherwise random stalls.
    always @(negedge i_clk) begin
        if (hold_ready_cycles > 0) begin
            res_ch.ready <= 1'b0;
            hold_ready_cycles--;
        end else begin
            res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Check each accepted result against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready)
            parity_board.check_result(res_ch.inside_res);
    end

    // Watchdog on cycles without progress on any channel.
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("point_in_polygon_test_core verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Offer one request, with random idle cycles first; returns on the falling edge after
    // acceptance with valid still high.
    task automatic push_request(input t_polygon_request req);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            item_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.kind         <= req.kind;
        item_ch.vertex_index <= req.index;
        item_ch.coord_x      <= req.x;
        item_ch.coord_y      <= req.y;
        do @(posedge i_clk); while (!item_ch.ready);
        parity_board.note_request(req);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic write_vertex(input int slot, input logic signed [COORD_W-1:0] x,
                                input logic signed [COORD_W-1:0] y);
        t_polygon_request req;
        req = '{kind: KIND_WRITE, index: slot[INDEX_W-1:0], x: x, y: y};
        push_request(req);
    endtask

    task automatic test_point(input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y);
        t_polygon_request req;
        req = '{kind: KIND_TEST, index: INDEX_W'($urandom), x: x, y: y};
        push_request(req);
    endtask

    // Stop offering, wait for every owed flag, then let a trailing write settle.
    task automatic drain_block();
        item_ch.valid <= 1'b0;
        while (parity_board.expected_flags.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_WAIT) @(negedge i_clk);
    endtask

    // Write the vertex count register; only called while the block is idle.
    task automatic write_count(input logic [COUNT_W-1:0] count);
        cfg_ch.valid        <= 1'b1;
        cfg_ch.vertex_count <= count;
        do @(posedge i_clk); while (!cfg_ch.ready);
        parity_board.vertex_count = count;
        counts_written++;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Coordinate source: full range, small window around zero, or mostly extremes, 0, +-1.
    function automatic logic signed [COORD_W-1:0] pick_coord(input int mode);
        int v;
        case (mode)
            0: v = $urandom;
            1: v = int'($urandom_range(0, 20)) - 10;
            default: begin
                case ($urandom_range(0, 5))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    3: v = -1;
                    4: v = 1;
                    default: v = $urandom;
                endcase
            end
        endcase
        return v[COORD_W-1:0];
    endfunction

    // Stimulus.
    initial begin
        int count_plan [8];
        int count;
        int used;
        int mode;
        int phase;
        int slot;
        int tx;
        int ty;
        count_plan = '{31, 16, 0, 3, 17, 1, 2, 4};

        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct  = 7;
        recv_stall_pct = 86;

        // Directed: empty polygon, a full-range square, then one and two vertices.
        test_point(16'sd0, 16'sd0);
        write_vertex(0, -16'sd32768, -16'sd32768);
        write_vertex(1,  16'sd32767, -16'sd32768);
        write_vertex(2,  16'sd32767,  16'sd32767);
        write_vertex(3, -16'sd32768,  16'sd32767);
        drain_block();
        write_count(5'd4);
        test_point(16'sd0, 16'sd0);
        test_point(-16'sd32768, 16'sd0);
        test_point(16'sd32767, 16'sd0);
        test_point(16'sd0, 16'sd32767);
        test_point(16'sd0, -16'sd32768);
        test_point(-16'sd32768, -16'sd32768);
        test_point(16'sd32767, 16'sd32767);
        drain_block();
        write_count(5'd1);
        test_point(16'sd5, 16'sd5);
        test_point(-16'sd32768, -16'sd32768);
        drain_block();
        write_count(5'd2);
        test_point(16'sd0, -16'sd32768);
        test_point(16'sd0, 16'sd0);

        // Random phases: a partly rewritten polygon for each count, then tests mixed with rewrites.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= 300) begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end else if (items_sent >= 150) begin
                send_idle_pct  = 86;
                recv_stall_pct = 7;
            end
            count = (phase < 8) ? count_plan[phase] : $urandom_range(0, 31);
            used  = (count > MAX_VERTS) ? MAX_VERTS : count;
            mode  = phase % 3;
            drain_block();
            write_count(count[COUNT_W-1:0]);
            for (int k = 0; k < used; k++) begin
                if (!parity_board.loaded[k] || $urandom_range(0, 1))
                    write_vertex(k, pick_coord(mode), pick_coord(mode));
            end
            // Hold results back long enough that the block fills and stalls its input.
            if (phase == 1)
                hold_ready_cycles = 300;
            for (int n = 0; n < 30; n++) begin
                if ($urandom_range(0, 3) == 0) begin
                    write_vertex($urandom_range(0, MAX_VERTS - 1), pick_coord(mode),
                                 pick_coord(mode));
                end else if (used > 0 && $urandom_range(0, 9) < 4) begin
                    // Points on or right next to a vertex hit the edge cases of the compare.
                    slot = $urandom_range(0, used - 1);
                    tx = int'(parity_board.vert_x[slot]) + int'($urandom_range(0, 2)) - 1;
                    ty = int'(parity_board.vert_y[slot]) + int'($urandom_range(0, 2)) - 1;
                    test_point(tx[COORD_W-1:0], ty[COORD_W-1:0]);
                end else begin
                    test_point(pick_coord(mode), pick_coord(mode));
                end
            end
            phase++;
        end

        drain_block();
        $display("Summary: %0d requests (%0d point tests, %0d vertex writes) over %0d counts.",
                 items_sent, parity_board.tests_seen, parity_board.writes_seen, counts_written);
        $display("Summary: %0d results checked, %0d of them inside.",
                 parity_board.results_seen, parity_board.flags_set);
        if (parity_board.expected_flags.size() != 0) begin
            $error("%0d inside_res results never arrived", parity_board.expected_flags.size());
            parity_board.mismatches++;
        end
        if (parity_board.mismatches == 0) begin
            $display("point_in_polygon_test_core verification clean");
        end else begin
            $display("point_in_polygon_test_core verification failed");
        end
        $finish;
    end

endmodule
